[hw/rtl/wbs_pkg.sv]
package wbs_pkg;

  // Position bias, the 3x3 pattern read row by row (first eight cells).
  localparam logic [3:0] POS_BIAS [8] = '{4'd3, 4'd2, 4'd3, 4'd2, 4'd4, 4'd2, 4'd3, 4'd2};

  localparam logic [3:0] WEIGHT_ONE  = 4'd10;
  localparam logic [3:0] WEIGHT_ZERO = 4'd5;

  // floor(x/9) == (x*57) >> 9 for every 8-bit x
  localparam logic [5:0]  RECIP9       = 6'd57;
  localparam int unsigned RECIP9_SHIFT = 9;
  localparam logic [4:0]  MOD_BASE     = 5'd9;
  localparam logic [4:0]  MOD_TWICE    = 5'd18;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

  // One queued transaction: up to two scramble jobs.
  // Job A: held byte, prev_a, next = byte_b. Job B: byte_b, prev_b, next = 0.
  typedef struct packed {
    logic [7:0] byte_a;
    logic [7:0] prev_a;
    logic [7:0] byte_b;
    logic [7:0] prev_b;
    logic       has_held;
    logic       is_end;
  } wbs_job_t;

  // Bit order per byte value; entry i of the order at bits [3*i +: 3].
  typedef logic [23:0] order_tbl_t [256];

  function automatic order_tbl_t build_order_table();
    order_tbl_t tbl;
    logic [3:0] wt [8];
    logic [2:0] ord [8];
    logic [3:0] tw;
    logic [2:0] to;
    logic [7:0] vb;
    logic [23:0] packed_ord;
    for (int v = 0; v < 256; v++) begin
      vb = 8'(v);
      for (int i = 0; i < 8; i++) begin
        ord[i] = 3'(i);
        wt[i]  = (vb[7 - i] ? WEIGHT_ONE : WEIGHT_ZERO) + POS_BIAS[i];
      end
      for (int i = 0; i < 7; i++) begin
        for (int j = i + 1; j < 8; j++) begin
          if (wt[j] > wt[i]) begin
            tw     = wt[i];
            wt[i]  = wt[j];
            wt[j]  = tw;
            to     = ord[i];
            ord[i] = ord[j];
            ord[j] = to;
          end
        end
      end
      packed_ord = '0;
      for (int i = 0; i < 8; i++) begin
        packed_ord[3 * i +: 3] = ord[i];
      end
      tbl[v] = packed_ord;
    end
    return tbl;
  endfunction

  localparam order_tbl_t ORDER_TABLE = build_order_table();

  function automatic logic [3:0] mod9_byte(input logic [7:0] x);
    logic [13:0] prod;
    logic [4:0]  q;
    logic [7:0]  q9;
    prod = 14'(x) * 14'(RECIP9);
    q    = prod[RECIP9_SHIFT +: 5];
    q9   = 8'({3'b000, q} * 8'd9);
    return 4'(x - q9);
  endfunction

  // ((a + b + c) mod 9) mod 8
  function automatic logic [2:0] rot_amount(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    logic [4:0] sum;
    logic [4:0] m;
    sum = 5'(mod9_byte(a)) + 5'(mod9_byte(b)) + 5'(mod9_byte(c));
    if (sum >= MOD_TWICE) begin
      m = sum - MOD_TWICE;
    end else if (sum >= MOD_BASE) begin
      m = sum - MOD_BASE;
    end else begin
      m = sum;
    end
    return m[2:0];
  endfunction

endpackage

[hw/rtl/wbs_front.sv]
module wbs_front import wbs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       stream_end,
  output logic       push,
  output wbs_job_t   push_job,
  input  logic       queue_full
);

  logic [7:0] held_byte;
  logic       held_valid;
  logic [7:0] previous_byte;
  logic       accept;
  logic [7:0] prev_b;

  assign in_stall = queue_full;
  assign accept   = in_valid && !queue_full;
  assign prev_b   = held_valid ? held_byte : previous_byte;

  // Items that only get held produce no job.
  assign push = accept && (held_valid || stream_end);

  always_comb begin
    push_job.byte_a   = held_byte;
    push_job.prev_a   = previous_byte;
    push_job.byte_b   = data_byte;
    push_job.prev_b   = prev_b;
    push_job.has_held = held_valid;
    push_job.is_end   = stream_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_byte     <= '0;
      held_valid    <= 1'b0;
      previous_byte <= '0;
    end else if (accept) begin
      if (stream_end) begin
        held_byte     <= '0;
        held_valid    <= 1'b0;
        previous_byte <= '0;
      end else begin
        held_byte     <= data_byte;
        held_valid    <= 1'b1;
        previous_byte <= prev_b;
      end
    end
  end

endmodule

[hw/rtl/wbs_queue.sv]
module wbs_queue import wbs_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  wbs_job_t push_job,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output wbs_job_t head_job
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  wbs_job_t         slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_FULL);
  assign head_valid = (count != '0);
  assign head_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= CNT_FULL)
    else $error("queue count out of range");
  a_count_grow: assert property (@(posedge clk) disable iff (rst)
      push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not grow on push");

endmodule

[hw/rtl/wbs_back.sv]
module wbs_back import wbs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  wbs_job_t   head_job,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] scrambled_byte,
  output logic       final_of_stream,
  output logic       last_in_run
);

  logic        phase;   // job A of a two-job entry already sent
  logic        use_a;
  logic        load;
  logic [7:0]  cur_byte;
  logic [7:0]  cur_prev;
  logic [7:0]  cur_next;
  logic [2:0]  rot;
  logic [23:0] order;
  logic [7:0]  perm;
  logic [2:0]  idx;
  logic [2:0]  pos;

  assign use_a    = head_job.has_held && !phase;
  assign cur_byte = use_a ? head_job.byte_a : head_job.byte_b;
  assign cur_prev = use_a ? head_job.prev_a : head_job.prev_b;
  assign cur_next = use_a ? head_job.byte_b : 8'd0;

  assign load = head_valid && (!out_valid || !out_stall);
  assign pop  = load && !(use_a && head_job.is_end);

  assign rot   = rot_amount(cur_byte, cur_prev, cur_next);
  assign order = ORDER_TABLE[cur_byte];

  always_comb begin
    perm = '0;
    idx  = '0;
    pos  = '0;
    for (int i = 0; i < 8; i++) begin
      idx          = 3'(i) + rot;
      pos          = order[3 * idx +: 3];
      perm[7 - i]  = cur_byte[3'd7 - pos];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        phase     <= use_a && head_job.is_end;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      scrambled_byte  <= perm;
      final_of_stream <= !use_a;
      last_in_run     <= !use_a || !head_job.is_end;
    end
  end

  a_phase_entry: assert property (@(posedge clk) disable iff (rst)
      phase |-> head_valid && head_job.has_held && head_job.is_end)
    else $error("second job pending without a two-job entry");
  a_final_is_last: assert property (@(posedge clk) disable iff (rst)
      out_valid && final_of_stream |-> last_in_run)
    else $error("stream end result not last of its run");
  a_phase_clears: assert property (@(posedge clk) disable iff (rst)
      phase && load |=> !phase)
    else $error("phase stuck after second job");

endmodule

[hw/rtl/weighted_bit_scramble_stream.sv]
// Byte-stream bit scrambler with one byte of look-ahead. Every byte is bit-permuted
// once its follower is known: its bits get weights (one/zero plus a fixed position
// bias), the positions are sorted by weight, the order is rotated by
// ((byte + prev + next) mod 9) mod 8 and the bits are gathered into scrambled_byte.
// A transaction with stream_end set closes the stream: the held byte (if any) and
// the closing byte both come out, the closing one scrambled with next = 0 and
// flagged final_of_stream, and the look-ahead state clears so the next stream
// starts with prev = 0. An input transaction yields zero, one or two results;
// last_in_run marks the final result of each. The first byte of a stream, unless it
// closes the stream, is only held and yields nothing until its follower arrives.
// Rate while out_stall is low: one result per clock; inputs go at one per clock
// except that a stream-closing byte behind a held byte makes two results, which
// both use the output port. Path to a result: the front classifies and enqueues
// into the job queue, the back scrambles into the output register.
module weighted_bit_scramble_stream import wbs_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       stream_end,
  // output channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] scrambled_byte,
  output logic       final_of_stream,
  output logic       last_in_run
);

  // front -> queue
  logic     push;
  wbs_job_t push_job;
  logic     queue_full;

  // queue -> back
  logic     head_valid;
  wbs_job_t head_job;
  logic     pop;

  // Front: owns the held/previous byte state, turns each accepted transaction
  // into a job entry (two scramble jobs at most).
  wbs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .stream_end (stream_end),
    .push       (push),
    .push_job   (push_job),
    .queue_full (queue_full)
  );

  // Short job queue decouples input stalls from output stalls.
  wbs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // Back: runs the permutation, one job per clock while out_stall is low, into the output register.
  wbs_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head_valid      (head_valid),
    .head_job        (head_job),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .scrambled_byte  (scrambled_byte),
    .final_of_stream (final_of_stream),
    .last_in_run     (last_in_run)
  );

endmodule
